// ===== src/hmf_pkg.sv =====
`default_nettype none

package hmf_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;

	// Length of "Content-Length:" in characters.
	localparam logic [3:0] KW_LEN = 4'd15;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_BLANKS,
		PH_DIGITS,
		PH_FIXED
	} phase_t;

	typedef enum logic [1:0] {
		TERM_IDLE,
		TERM_CR,
		TERM_CRLF,
		TERM_CRLFCR
	} term_t;

	typedef struct packed {
		logic step;
		logic clear;
	} scan_ctrl_t;

	typedef struct packed {
		logic has_len;
		logic ovf;
	} scan_stat_t;

	typedef struct packed {
		logic is_body;
		logic header_end;
		logic message_last;
		logic length_saturated;
	} out_flags_t;

	function automatic logic [7:0] kw_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0:    c = 8'h43; // C
			4'd1:    c = 8'h6F; // o
			4'd2:    c = 8'h6E; // n
			4'd3:    c = 8'h74; // t
			4'd4:    c = 8'h65; // e
			4'd5:    c = 8'h6E; // n
			4'd6:    c = 8'h74; // t
			4'd7:    c = 8'h2D; // -
			4'd8:    c = 8'h4C; // L
			4'd9:    c = 8'h65; // e
			4'd10:   c = 8'h6E; // n
			4'd11:   c = 8'h67; // g
			4'd12:   c = 8'h74; // t
			4'd13:   c = 8'h68; // h
			4'd14:   c = CH_COLON;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== src/hmf_in_reg.sv =====
`default_nettype none

module hmf_in_reg
	import hmf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// The stage takes a new byte whenever it is empty or its byte moves on now.
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

// ===== src/hmf_length_scan.sv =====
`default_nettype none

module hmf_length_scan
	import hmf_pkg::*;
#(
	parameter int LENGTH_WIDTH = 32
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire scan_ctrl_t              ctrl,
	input  wire logic [7:0]              scan_byte,
	output logic [LENGTH_WIDTH-1:0]      len,
	output scan_stat_t                   stat
);

	logic [3:0]              kw_cnt_q, kw_cnt_n;
	phase_t                  phase_q, phase_n;
	logic [LENGTH_WIDTH-1:0] acc_q, acc_n;
	logic                    ovf_q, ovf_n;

	logic                    is_digit;
	logic [LENGTH_WIDTH-1:0] add_base;
	logic [LENGTH_WIDTH+3:0] add_wide;
	logic [LENGTH_WIDTH-1:0] add_val;
	logic                    add_ovf;

	assign is_digit = (scan_byte >= CH_ZERO) && (scan_byte <= CH_NINE);

	// One decimal digit: acc * 10 + d, computed with four spare bits so that
	// anything above the counter range shows in the top bits.
	assign add_base = (phase_q == PH_DIGITS) ? acc_q : '0;
	assign add_wide = ({4'b0000, add_base} << 3) + ({4'b0000, add_base} << 1)
		+ {{LENGTH_WIDTH{1'b0}}, scan_byte[3:0]};
	assign add_ovf  = (add_wide[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'b0000);
	assign add_val  = add_ovf ? {LENGTH_WIDTH{1'b1}} : add_wide[LENGTH_WIDTH-1:0];

	always_comb begin
		kw_cnt_n = kw_cnt_q;
		phase_n  = phase_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		case (phase_q)
			PH_SEARCH: begin
				if (kw_cnt_q != KW_LEN && scan_byte == kw_char(kw_cnt_q)) begin
					if (kw_cnt_q + 4'd1 == KW_LEN) begin
						kw_cnt_n = 4'd0;
						phase_n  = PH_BLANKS;
					end else begin
						kw_cnt_n = kw_cnt_q + 4'd1;
					end
				end else begin
					kw_cnt_n = (scan_byte == kw_char(4'd0)) ? 4'd1 : 4'd0;
				end
			end
			PH_BLANKS: begin
				if (scan_byte == CH_SPACE || scan_byte == CH_TAB) begin
					phase_n = PH_BLANKS;
				end else if (is_digit) begin
					acc_n   = add_val;
					ovf_n   = ovf_q | add_ovf;
					phase_n = PH_DIGITS;
				end else begin
					acc_n   = '0;
					phase_n = PH_FIXED;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					acc_n = add_val;
					ovf_n = ovf_q | add_ovf;
				end else begin
					phase_n = PH_FIXED;
				end
			end
			default: begin
				phase_n = PH_FIXED;
			end
		endcase
	end

	assign stat.has_len = (phase_n == PH_DIGITS) || (phase_n == PH_FIXED);
	assign stat.ovf     = ctrl.step ? ovf_n : ovf_q;
	assign len          = stat.has_len ? acc_n : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kw_cnt_q <= 4'd0;
			phase_q  <= PH_SEARCH;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (ctrl.clear) begin
			kw_cnt_q <= 4'd0;
			phase_q  <= PH_SEARCH;
			acc_q    <= '0;
			ovf_q    <= 1'b0;
		end else if (ctrl.step) begin
			kw_cnt_q <= kw_cnt_n;
			phase_q  <= phase_n;
			acc_q    <= acc_n;
			ovf_q    <= ovf_n;
		end
	end

endmodule

`default_nettype wire

// ===== src/hmf_out_reg.sv =====
`default_nettype none

module hmf_out_reg
	import hmf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       load,
	input  wire logic [7:0] load_byte,
	input  wire out_flags_t load_flags,
	output logic            free,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            is_body,
	output logic            header_end,
	output logic            message_last,
	output logic            length_saturated
);

	out_flags_t flags_q;

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= load_byte;
			flags_q  <= load_flags;
		end
	end

	assign is_body          = flags_q.is_body;
	assign header_end       = flags_q.header_end;
	assign message_last     = flags_q.message_last;
	assign length_saturated = flags_q.length_saturated;

endmodule

`default_nettype wire

// ===== src/http_message_framer_core.sv =====
// HTTP/1.1 message framer for one connection's received byte stream.
// The input channel (in_valid, in_ready, rx_byte) carries one byte per
// transaction. The output channel (out_valid, out_ready and the result fields)
// returns exactly one transaction per input byte, in order: the byte itself,
// is_body for message body bytes, header_end on the final LF of CR LF CR LF,
// message_last on the last byte of each message, and length_saturated when
// the Content-Length value did not fit in LENGTH_WIDTH bits and was clamped.
// A byte accepted into the input stage waits there until the result register
// is free, is then framed into the result register and is shown on the
// outputs from then on, until the receiver takes it. Throughput is one byte
// per cycle while the receiver does not stall; the framing state is updated
// in a single pass as a byte leaves the input stage.
// When the receiver stalls, the result register holds its transaction and the
// input stage still takes one more byte; after that in_ready drops until the
// result is taken. Reset clears both stages and all framing state, so the
// first byte after reset starts the header of a new message.
`default_nettype none

module http_message_framer_core
	import hmf_pkg::*;
#(
	parameter int LENGTH_WIDTH = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            is_body,
	output logic            header_end,
	output logic            message_last,
	output logic            length_saturated
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       advance;

	// Message-level state: terminator progress and the body counter.
	term_t                   term_q, term_n;
	logic                    body_active_q, body_active_n;
	logic [LENGTH_WIDTH-1:0] body_left_q, body_left_n;

	scan_ctrl_t              scan_ctrl;
	scan_stat_t              scan_stat;
	logic [LENGTH_WIDTH-1:0] scan_len;
	out_flags_t              flags_n;

	// A byte leaves the input stage whenever the result register can take it.
	assign advance = valid_s1 && out_free;

	hmf_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	hmf_length_scan #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_length_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (scan_ctrl),
		.scan_byte (byte_s1),
		.len       (scan_len),
		.stat      (scan_stat)
	);

	// Header bytes drive the terminator search and, at CR LF CR LF, either
	// close the message or load the body counter. Body bytes only count down
	// and are never searched.
	always_comb begin
		term_n        = term_q;
		body_active_n = body_active_q;
		body_left_n   = body_left_q;
		flags_n       = '0;
		if (body_active_q) begin
			flags_n.is_body = 1'b1;
			body_left_n     = body_left_q - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};
			if (body_left_n == '0) begin
				flags_n.message_last = 1'b1;
			end
		end else if (byte_s1 == CH_CR) begin
			term_n = (term_q == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
		end else if (byte_s1 == CH_LF && term_q == TERM_CR) begin
			term_n = TERM_CRLF;
		end else if (byte_s1 == CH_LF && term_q == TERM_CRLFCR) begin
			flags_n.header_end = 1'b1;
			term_n             = TERM_IDLE;
			if (scan_len == '0) begin
				flags_n.message_last = 1'b1;
			end else begin
				body_active_n = 1'b1;
				body_left_n   = scan_len;
			end
		end else begin
			term_n = TERM_IDLE;
		end
		// The flag reported is the one standing after this byte, before the
		// end of the message clears it.
		flags_n.length_saturated = scan_stat.ovf;
	end

	assign scan_ctrl.step  = advance && !body_active_q;
	assign scan_ctrl.clear = advance && flags_n.message_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q        <= TERM_IDLE;
			body_active_q <= 1'b0;
			body_left_q   <= '0;
		end else if (advance) begin
			if (flags_n.message_last) begin
				term_q        <= TERM_IDLE;
				body_active_q <= 1'b0;
				body_left_q   <= '0;
			end else begin
				term_q        <= term_n;
				body_active_q <= body_active_n;
				body_left_q   <= body_left_n;
			end
		end
	end

	hmf_out_reg u_out_reg (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (advance),
		.load_byte        (byte_s1),
		.load_flags       (flags_n),
		.free             (out_free),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_byte         (out_byte),
		.is_body          (is_body),
		.header_end       (header_end),
		.message_last     (message_last),
		.length_saturated (length_saturated)
	);

	// While the body is counted, at least one body byte is still owed.
	a_body_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		body_active_q |-> (body_left_q != '0))
		else $error("body counter is zero while the body is active");

	// The terminator search is idle during the body.
	a_term_idle_in_body: assert property (@(posedge clk) disable iff (!arst_n)
		body_active_q |-> (term_q == TERM_IDLE))
		else $error("terminator search active inside the body");

	// A header terminator is never reported on a body byte.
	a_hend_not_body: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && header_end |-> !is_body)
		else $error("header_end marked on a body byte");

	// Closing a message returns the framing state to its start.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && flags_n.message_last |=> !body_active_q && (term_q == TERM_IDLE))
		else $error("framing state not cleared after the last byte of a message");

endmodule

`default_nettype wire
